@@ design/pse_pkg.sv @@
// shared constants and types for the polynomial store evaluator
package pse_pkg;

   localparam int DEF_MAX_DEGREE = 31;

   localparam int ACT_W  = 2;
   localparam int EXP_W  = 5;
   localparam int Q_W    = 32;
   localparam int FRAC_W = 16;
   localparam int DEG_W  = 5;
   localparam int PROD_W = 2 * Q_W;
   // rounded q16.16 product (48 bits) plus a term, with one bit of headroom
   localparam int SUM_W  = PROD_W - FRAC_W + 1;

   typedef logic signed [Q_W-1:0] q_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_SET   = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_EVAL  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH,
      S_COMMIT,
      S_SCAN,
      S_EVAL,
      S_TAIL,
      S_DRAIN,
      S_INTEG,
      S_DONE
   } state_type;

endpackage

@@ design/pse_if.sv @@
// request and response channel interfaces of the polynomial store evaluator
interface pse_req_if;
   import pse_pkg::*;

   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [EXP_W-1:0]  exponent;
   q_type             amount;
   q_type             x_low;
   q_type             x_high;

   modport source (output valid, action, exponent, amount, x_low, x_high, input ready);
   modport sink   (input valid, action, exponent, amount, x_low, x_high, output ready);
endinterface

interface pse_rsp_if;
   import pse_pkg::*;

   logic              valid;
   logic              ready;
   q_type             value;
   q_type             slope;
   q_type             integral;
   logic [DEG_W-1:0]  degree;
   logic              is_zero;
   logic              saturated;

   modport source (output valid, value, slope, integral, degree, is_zero, saturated,
                   input ready);
   modport sink   (input valid, value, slope, integral, degree, is_zero, saturated,
                   output ready);
endinterface

@@ design/pse_ram.sv @@
// generic single-clock ram, one write port and one registered read port
module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/polynomial_store_evaluator_core.sv @@
// top level of the polynomial store evaluator: store, degree tracking and horner engine
//
// holds MAX_DEGREE+1 signed q16.16 coefficients in a single-port-read ram, one
// nonzero flag per entry in flops (an entry whose flag is low reads as zero, so
// reset and clear take effect at once with no clearing pass), and the current
// degree. one transfer at a time is worked on; the next request transfer is taken
// as soon as the previous result sits in the output register. set and add read
// the coefficient, merge and write it back, then give the result, after a scan
// downward through the flags for the new degree when the top coefficient goes
// to zero. clear goes straight to its result. for evaluate the ram read port
// walks the coefficients from the top one per cycle, a four-stage term pipeline
// forms c, i*c and the rounded c/(i+1), and four horner accumulators (value, slope,
// antiderivative at x_high and at x_low) take one step per cycle, with one extra
// antiderivative step, then the clamped integral. every result carries the degree
// and zero flag after the transfer and a saturation flag for any clamp it caused.
module polynomial_store_evaluator_core #(
   parameter int MAX_DEGREE = pse_pkg::DEF_MAX_DEGREE
) (
   input  logic      clock,
   input  logic      reset,
   pse_req_if.sink   req_ch,
   pse_rsp_if.source rsp_ch
);
   import pse_pkg::*;

   localparam int DEPTH   = MAX_DEGREE + 1;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int K_W     = IDX_W + 1;
   localparam int RCP_W   = Q_W + 1;
   localparam int SLOPE_W = IDX_W + Q_W + 1;
   localparam int REM_W   = Q_W + K_W;
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(MAX_DEGREE);

   typedef struct packed {
      q_type value;
      logic  sat;
   } clamp_type;

   // clamp a wide signed sum into the q16.16 range
   function automatic clamp_type clamp_q(logic signed [SUM_W-1:0] v);
      clamp_type r;
      if (v[SUM_W-1:Q_W-1] == '0 || v[SUM_W-1:Q_W-1] == '1) begin
         r.value = v[Q_W-1:0];
         r.sat   = 1'b0;
      end else if (v[SUM_W-1]) begin
         r.value = {1'b1, {(Q_W-1){1'b0}}};
         r.sat   = 1'b1;
      end else begin
         r.value = {1'b0, {(Q_W-1){1'b1}}};
         r.sat   = 1'b1;
      end
      return r;
   endfunction

   // one horner step: round-half-up q16.16 product plus term, then clamp
   function automatic clamp_type horner_step(q_type acc, q_type x,
                                             logic signed [SUM_W-1:0] term);
      logic signed [PROD_W-1:0] prod;
      logic signed [SUM_W-1:0]  sum;
      prod = PROD_W'(acc) * PROD_W'(x) + (PROD_W'(1) <<< (FRAC_W - 1));
      sum  = SUM_W'(prod >>> FRAC_W) + term;
      return clamp_q(sum);
   endfunction

   // reciprocal table floor(2^32 / k) for k = 1 .. DEPTH
   logic [RCP_W-1:0] recip_tab [DEPTH];
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_recip
      localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << Q_W) / (gi + 1));
      assign recip_tab[gi] = RECIP;
   end

   // control state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_cnt_ff, idx_cnt_in;
   logic [IDX_W-1:0] deg_ff, deg_in;
   logic [DEPTH-1:0] nz_ff, nz_in;
   logic             sat_ff, sat_in;

   // transfer held while it is worked on
   action_type       act_ff, act_in;
   logic [IDX_W-1:0] exp_ff, exp_in;
   q_type            amount_ff, amount_in;
   q_type            x_low_ff, x_low_in;
   q_type            x_high_ff, x_high_in;

   // horner accumulators and integral
   q_type            val_ff, val_in;
   q_type            slp_ff, slp_in;
   q_type            ahi_ff, ahi_in;
   q_type            alo_ff, alo_in;
   q_type            int_ff, int_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   q_type            rsp_value_ff, rsp_value_in;
   q_type            rsp_slope_ff, rsp_slope_in;
   q_type            rsp_integral_ff, rsp_integral_in;
   logic [DEG_W-1:0] rsp_degree_ff, rsp_degree_in;
   logic             rsp_zero_ff, rsp_zero_in;
   logic             rsp_sat_ff, rsp_sat_in;

   // fsm outputs
   logic             req_ready;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic             issue_vld;
   logic             issue_tail;
   logic             rsp_load;

   // ram
   q_type            rd_data;
   logic             rd_nz_ff, rd_nz_in;

   // term pipeline
   logic             p0_vld_ff, p0_vld_in;
   logic             p0_tail_ff, p0_tail_in;
   logic [IDX_W-1:0] p0_idx_ff, p0_idx_in;

   logic             s1_vld_ff, s1_vld_in;
   logic             s1_tail_ff, s1_tail_in;
   logic [IDX_W-1:0] s1_idx_ff, s1_idx_in;
   q_type            s1_coef_ff, s1_coef_in;
   logic             s1_neg_ff, s1_neg_in;
   logic [Q_W-1:0]   s1_num_ff, s1_num_in;

   logic             s2_vld_ff, s2_vld_in;
   logic             s2_tail_ff, s2_tail_in;
   logic [IDX_W-1:0] s2_idx_ff, s2_idx_in;
   q_type            s2_coef_ff, s2_coef_in;
   logic             s2_neg_ff, s2_neg_in;
   logic [Q_W-1:0]   s2_num_ff, s2_num_in;
   logic [RCP_W+Q_W-1:0]       s2_prod_ff, s2_prod_in;
   logic signed [SLOPE_W-1:0]  s2_slope_ff, s2_slope_in;

   logic             s3_vld_ff, s3_vld_in;
   logic             s3_tail_ff, s3_tail_in;
   logic [IDX_W-1:0] s3_idx_ff, s3_idx_in;
   q_type            s3_coef_ff, s3_coef_in;
   logic signed [SLOPE_W-1:0]  s3_slope_ff, s3_slope_in;
   logic signed [RCP_W-1:0]    s3_anti_ff, s3_anti_in;

   // combinational helpers
   logic                      req_fire;
   logic                      req_exp_ok;
   logic [IDX_W+EXP_W-1:0]    req_exp_wide;
   logic [IDX_W+DEG_W-1:0]    deg_wide;
   q_type                     old_coef;
   clamp_type                 add_res;
   q_type                     new_coef;
   logic                      new_nz;
   logic                      need_scan;
   logic                      scan_hit;
   clamp_type                 val_step;
   clamp_type                 slp_step;
   clamp_type                 ahi_step;
   clamp_type                 alo_step;
   clamp_type                 int_res;
   logic                      slp_en;
   logic signed [SUM_W-1:0]   anti_term;

   q_type                     coef0;
   logic [Q_W-1:0]            mag0;
   logic [K_W-1:0]            k0;
   logic [K_W-1:0]            k2;
   logic [RCP_W-1:0]          q0;
   logic [REM_W-1:0]          rem2;
   logic [RCP_W-1:0]          qr;

   assign req_fire     = req_ch.valid && req_ready;
   assign req_exp_wide = (IDX_W + EXP_W)'(req_ch.exponent);
   assign req_exp_ok   = int'(req_ch.exponent) <= MAX_DEGREE;
   assign deg_wide     = (IDX_W + DEG_W)'(deg_ff);

   // coefficient memory; the nonzero flags decide whether its data counts
   pse_ram #(
      .WIDTH (Q_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (exp_ff),
      .wr_data (new_coef),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- fsm
   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (action_type'(req_ch.action))
                  ACT_SET, ACT_ADD: state_in = req_exp_ok ? S_FETCH : S_DONE;
                  ACT_CLEAR:        state_in = S_DONE;
                  ACT_EVAL:         state_in = S_EVAL;
                  default:          state_in = S_DONE;
               endcase
            end
         end
         S_FETCH:  state_in = S_COMMIT;
         S_COMMIT: state_in = need_scan ? S_SCAN : S_DONE;
         S_SCAN:   state_in = scan_hit ? S_DONE : S_SCAN;
         S_EVAL:   state_in = (idx_cnt_ff == '0) ? S_TAIL : S_EVAL;
         S_TAIL:   state_in = S_DRAIN;
         S_DRAIN:  state_in = (s3_vld_ff && s3_tail_ff) ? S_INTEG : S_DRAIN;
         S_INTEG:  state_in = S_DONE;
         S_DONE:   state_in = rsp_load ? S_IDLE : S_DONE;
         default:  state_in = S_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready  = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = exp_ff;
      wr_en      = 1'b0;
      issue_vld  = 1'b0;
      issue_tail = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_ready = 1'b1;
         S_FETCH:  rd_en = 1'b1;
         S_COMMIT: wr_en = 1'b1;
         S_EVAL: begin
            rd_en     = 1'b1;
            rd_addr   = idx_cnt_ff;
            issue_vld = 1'b1;
         end
         // one more antiderivative step with a zero term
         S_TAIL: begin
            issue_vld  = 1'b1;
            issue_tail = 1'b1;
         end
         S_DONE:   rsp_load = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   // ------------------------------------------------------ set / add merge
   assign old_coef  = rd_nz_ff ? rd_data : '0;
   assign add_res   = clamp_q(SUM_W'(old_coef) + SUM_W'(amount_ff));
   assign new_coef  = (act_ff == ACT_SET) ? amount_ff : add_res.value;
   assign new_nz    = new_coef != '0;
   // top coefficient went to zero: search downward for the new degree
   assign need_scan = !new_nz && exp_ff == deg_ff && exp_ff != '0;
   assign scan_hit  = nz_ff[idx_cnt_ff] || idx_cnt_ff == '0;

   // ------------------------------------------------------- term pipeline
   always_comb begin
      p0_vld_in  = issue_vld;
      p0_tail_in = issue_tail;
      p0_idx_in  = idx_cnt_ff;
      rd_nz_in   = nz_ff[rd_addr];

      // stage 1: coefficient, magnitude plus half divisor for rounding
      coef0      = (rd_nz_ff && !p0_tail_ff) ? rd_data : '0;
      mag0       = coef0[Q_W-1] ? Q_W'(-coef0) : Q_W'(coef0);
      k0         = K_W'(p0_idx_ff) + K_W'(1);
      s1_vld_in  = p0_vld_ff;
      s1_tail_in = p0_tail_ff;
      s1_idx_in  = p0_idx_ff;
      s1_coef_in = coef0;
      s1_neg_in  = coef0[Q_W-1];
      s1_num_in  = mag0 + Q_W'(k0 >> 1);

      // stage 2: reciprocal product and derivative term
      s2_vld_in   = s1_vld_ff;
      s2_tail_in  = s1_tail_ff;
      s2_idx_in   = s1_idx_ff;
      s2_coef_in  = s1_coef_ff;
      s2_neg_in   = s1_neg_ff;
      s2_num_in   = s1_num_ff;
      s2_prod_in  = (RCP_W + Q_W)'(s1_num_ff) * (RCP_W + Q_W)'(recip_tab[s1_idx_ff]);
      s2_slope_in = SLOPE_W'($signed({1'b0, s1_idx_ff})) * SLOPE_W'(s1_coef_ff);

      // stage 3: quotient estimate is low by at most one, fix with the remainder
      k2          = K_W'(s2_idx_ff) + K_W'(1);
      q0          = s2_prod_ff[RCP_W+Q_W-1:Q_W];
      rem2        = REM_W'(s2_num_ff) - REM_W'(q0) * REM_W'(k2);
      qr          = q0 + RCP_W'(rem2 >= REM_W'(k2));
      s3_vld_in   = s2_vld_ff;
      s3_tail_in  = s2_tail_ff;
      s3_idx_in   = s2_idx_ff;
      s3_coef_in  = s2_coef_ff;
      s3_slope_in = s2_slope_ff;
      s3_anti_in  = s2_neg_ff ? -$signed(qr) : $signed(qr);
   end

   // ---------------------------------------------------- horner accumulators
   assign anti_term = SUM_W'(s3_anti_ff);
   assign slp_en    = !s3_tail_ff && s3_idx_ff != '0;
   assign val_step  = horner_step(val_ff, x_high_ff, SUM_W'(s3_coef_ff));
   assign slp_step  = horner_step(slp_ff, x_high_ff, SUM_W'(s3_slope_ff));
   assign ahi_step  = horner_step(ahi_ff, x_high_ff, anti_term);
   assign alo_step  = horner_step(alo_ff, x_low_ff, anti_term);
   assign int_res   = clamp_q(SUM_W'(ahi_ff) - SUM_W'(alo_ff));

   // ------------------------------------------------------- state update
   always_comb begin
      idx_cnt_in = idx_cnt_ff;
      deg_in     = deg_ff;
      nz_in      = nz_ff;
      sat_in     = sat_ff;
      act_in     = act_ff;
      exp_in     = exp_ff;
      amount_in  = amount_ff;
      x_low_in   = x_low_ff;
      x_high_in  = x_high_ff;
      val_in     = val_ff;
      slp_in     = slp_ff;
      ahi_in     = ahi_ff;
      alo_in     = alo_ff;
      int_in     = int_ff;

      // latch a new transfer
      if (req_fire) begin
         act_in     = action_type'(req_ch.action);
         exp_in     = req_exp_wide[IDX_W-1:0];
         amount_in  = req_ch.amount;
         x_low_in   = req_ch.x_low;
         x_high_in  = req_ch.x_high;
         sat_in     = 1'b0;
         idx_cnt_in = TOP_IDX;
         val_in     = '0;
         slp_in     = '0;
         ahi_in     = '0;
         alo_in     = '0;
         int_in     = '0;
         if (action_type'(req_ch.action) == ACT_CLEAR) begin
            nz_in  = '0;
            deg_in = '0;
         end
      end

      // write back a set or add and track the degree
      if (state_ff == S_COMMIT) begin
         nz_in[exp_ff] = new_nz;
         if (act_ff == ACT_ADD) begin
            sat_in = sat_ff | add_res.sat;
         end
         if (new_nz && exp_ff > deg_ff) begin
            deg_in = exp_ff;
         end
         if (need_scan) begin
            idx_cnt_in = exp_ff - IDX_W'(1);
         end
      end

      if (state_ff == S_SCAN) begin
         if (scan_hit) begin
            deg_in = idx_cnt_ff;
         end else begin
            idx_cnt_in = idx_cnt_ff - IDX_W'(1);
         end
      end

      // read address walks down from the top coefficient
      if (state_ff == S_EVAL && idx_cnt_ff != '0) begin
         idx_cnt_in = idx_cnt_ff - IDX_W'(1);
      end

      if (s3_vld_ff) begin
         ahi_in = ahi_step.value;
         alo_in = alo_step.value;
         sat_in = sat_in | ahi_step.sat | alo_step.sat;
         if (!s3_tail_ff) begin
            val_in = val_step.value;
            sat_in = sat_in | val_step.sat;
         end
         if (slp_en) begin
            slp_in = slp_step.value;
            sat_in = sat_in | slp_step.sat;
         end
      end

      if (state_ff == S_INTEG) begin
         int_in = int_res.value;
         sat_in = sat_in | int_res.sat;
      end
   end

   // ------------------------------------------------------ output register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in    = rsp_value_ff;
      rsp_slope_in    = rsp_slope_ff;
      rsp_integral_in = rsp_integral_ff;
      rsp_degree_in   = rsp_degree_ff;
      rsp_zero_in     = rsp_zero_ff;
      rsp_sat_in      = rsp_sat_ff;
      if (rsp_load) begin
         rsp_valid_in    = 1'b1;
         rsp_value_in    = (act_ff == ACT_EVAL) ? val_ff : '0;
         rsp_slope_in    = (act_ff == ACT_EVAL) ? slp_ff : '0;
         rsp_integral_in = (act_ff == ACT_EVAL) ? int_ff : '0;
         rsp_degree_in   = deg_wide[DEG_W-1:0];
         rsp_zero_in     = deg_ff == '0 && !nz_ff[0];
         rsp_sat_in      = sat_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_cnt_ff   <= '0;
         deg_ff       <= '0;
         nz_ff        <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         p0_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_cnt_ff   <= idx_cnt_in;
         deg_ff       <= deg_in;
         nz_ff        <= nz_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         p0_vld_ff    <= p0_vld_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         s3_vld_ff    <= s3_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      exp_ff          <= exp_in;
      amount_ff       <= amount_in;
      x_low_ff        <= x_low_in;
      x_high_ff       <= x_high_in;
      val_ff          <= val_in;
      slp_ff          <= slp_in;
      ahi_ff          <= ahi_in;
      alo_ff          <= alo_in;
      int_ff          <= int_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_slope_ff    <= rsp_slope_in;
      rsp_integral_ff <= rsp_integral_in;
      rsp_degree_ff   <= rsp_degree_in;
      rsp_zero_ff     <= rsp_zero_in;
      rsp_sat_ff      <= rsp_sat_in;
      rd_nz_ff        <= rd_nz_in;
      p0_tail_ff      <= p0_tail_in;
      p0_idx_ff       <= p0_idx_in;
      s1_tail_ff      <= s1_tail_in;
      s1_idx_ff       <= s1_idx_in;
      s1_coef_ff      <= s1_coef_in;
      s1_neg_ff       <= s1_neg_in;
      s1_num_ff       <= s1_num_in;
      s2_tail_ff      <= s2_tail_in;
      s2_idx_ff       <= s2_idx_in;
      s2_coef_ff      <= s2_coef_in;
      s2_neg_ff       <= s2_neg_in;
      s2_num_ff       <= s2_num_in;
      s2_prod_ff      <= s2_prod_in;
      s2_slope_ff     <= s2_slope_in;
      s3_tail_ff      <= s3_tail_in;
      s3_idx_ff       <= s3_idx_in;
      s3_coef_ff      <= s3_coef_in;
      s3_slope_ff     <= s3_slope_in;
      s3_anti_ff      <= s3_anti_in;
   end

   // ports
   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.value     = rsp_value_ff;
   assign rsp_ch.slope     = rsp_slope_ff;
   assign rsp_ch.integral  = rsp_integral_ff;
   assign rsp_ch.degree    = rsp_degree_ff;
   assign rsp_ch.is_zero   = rsp_zero_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   // ---------------------------------------------------------- assertions
   // between transfers the degree points at a nonzero entry unless it is zero
   a_deg_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && deg_ff != '0) |-> nz_ff[deg_ff])
      else $error("degree points at a zero coefficient");

   // between transfers no nonzero entry lies above the degree
   a_deg_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((nz_ff >> deg_ff) >> 1) == '0)
      else $error("nonzero coefficient above the degree");

   // the accumulators only step while an evaluation is in flight
   a_pipe_busy: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff |-> (state_ff == S_EVAL || state_ff == S_TAIL || state_ff == S_DRAIN))
      else $error("term pipeline active outside an evaluation");

   // the integral is formed right after the last antiderivative step
   a_integ_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INTEG) |-> $past(s3_vld_ff && s3_tail_ff))
      else $error("integral taken before the accumulators settled");

endmodule

@@ tb/sv/polynomial_store_evaluator_core_tb.sv @@
// testbench of polynomial_store_evaluator_core: random and directed store edits and evaluations
`timescale 1ns / 1ps

module polynomial_store_evaluator_core_tb;
   import pse_pkg::*;

   localparam int     MAX_DEG      = DEF_MAX_DEGREE;
   localparam int     RANDOM_ITEMS = 700;
   localparam int     DRAIN_CYCLES = 3 * MAX_DEG + 40;   // eval plus a full degree search
   localparam int     CYCLE_LIMIT  = 600000;
   localparam longint Q_HI         = 64'sd2147483647;
   localparam longint Q_LO         = -Q_HI - 1;
   localparam q_type  Q_ONE        = 32'sh0001_0000;
   localparam q_type  Q_HALF       = 32'sh0000_8000;

   // one request transfer
   typedef struct {
      action_type        action;
      logic [EXP_W-1:0]  exponent;
      q_type             amount;
      q_type             x_low;
      q_type             x_high;
   } poly_request_t;

   // one response transfer
   typedef struct {
      q_type             value;
      q_type             slope;
      q_type             integral;
      logic [DEG_W-1:0]  degree;
      logic              is_zero;
      logic              saturated;
   } poly_result_t;

   logic clock;
   logic reset;

   pse_req_if req_bus ();
   pse_rsp_if rsp_bus ();

   polynomial_store_evaluator_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // stimulus not yet on the bus, and results owed by the block
   poly_request_t request_backlog [$];
   poly_result_t  predicted_results [$];

   // shadow copy of the coefficient store and its degree
   q_type            coef_model [0:MAX_DEG];
   logic [DEG_W-1:0] deg_model;

   poly_request_t on_bus;
   poly_result_t  got, want;
   int            error_count    = 0;
   int            accepted_count = 0;
   int            cycle_count    = 0;
   int            send_hold      = 0;
   int            ready_hold     = 0;
   bit            send_calm      = 0;
   bit            ready_calm     = 0;
   int            total_items;

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint sat_clamp(longint v, inout bit clipped);
      if (v > Q_HI) begin
         clipped = 1'b1;
         return Q_HI;
      end
      if (v < Q_LO) begin
         clipped = 1'b1;
         return Q_LO;
      end
      return v;
   endfunction

   // q16.16 product, round half up (arithmetic shift floors)
   function automatic longint q_mul(longint a, longint b);
      return (a * b + 64'sd32768) >>> 16;
   endfunction

   // horner on c_i/(i+1), rounded to nearest with ties away from zero, then one more step
   function automatic longint antiderivative_at(longint x, inout bit clipped);
      longint acc, c, mag, k, q;
      acc = 0;
      for (int i = MAX_DEG; i >= 0; i--) begin
         c   = coef_model[i];
         k   = i + 1;
         mag = (c < 0) ? -c : c;
         q   = (mag + k / 2) / k;
         acc = sat_clamp(q_mul(acc, x) + ((c < 0) ? -q : q), clipped);
      end
      return sat_clamp(q_mul(acc, x), clipped);
   endfunction

   // applies one accepted request to the shadow store and returns the response it owes
   function automatic poly_result_t apply_to_store(poly_request_t r);
      poly_result_t res;
      bit           clipped;
      longint       acc, x;
      clipped = 1'b0;
      res     = '{default: '0};
      case (r.action)
         ACT_SET: begin
            if (r.exponent <= MAX_DEG)
               coef_model[r.exponent] = r.amount;
         end
         ACT_ADD: begin
            if (r.exponent <= MAX_DEG)
               coef_model[r.exponent] = q_type'(sat_clamp(
                  longint'(coef_model[r.exponent]) + longint'(r.amount), clipped));
         end
         ACT_CLEAR: begin
            foreach (coef_model[i]) coef_model[i] = '0;
            deg_model = '0;
         end
         default: begin
            x   = r.x_high;
            acc = 0;
            for (int i = MAX_DEG; i >= 0; i--)
               acc = sat_clamp(q_mul(acc, x) + longint'(coef_model[i]), clipped);
            res.value = q_type'(acc);
            acc = 0;
            for (int i = MAX_DEG; i >= 1; i--)
               acc = sat_clamp(q_mul(acc, x) + longint'(i) * longint'(coef_model[i]), clipped);
            res.slope = q_type'(acc);
            acc = antiderivative_at(x, clipped);
            acc = acc - antiderivative_at(longint'(r.x_low), clipped);
            res.integral = q_type'(sat_clamp(acc, clipped));
         end
      endcase
      // degree is searched again after any write
      if ((r.action == ACT_SET || r.action == ACT_ADD) && r.exponent <= MAX_DEG) begin
         deg_model = '0;
         for (int i = 0; i <= MAX_DEG; i++)
            if (coef_model[i] != 0) deg_model = DEG_W'(i);
      end
      res.degree    = deg_model;
      res.is_zero   = (deg_model == 0 && coef_model[0] == 0);
      res.saturated = clipped;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic void queue_item(action_type a, logic [EXP_W-1:0] e, q_type amount,
                                      q_type lo, q_type hi);
      poly_request_t item;
      item.action   = a;
      item.exponent = e;
      item.amount   = amount;
      item.x_low    = lo;
      item.x_high   = hi;
      request_backlog.push_back(item);
   endfunction

   // signed value of at most the given magnitude bits, either sign
   function automatic q_type rand_q(int bits);
      q_type mag;
      mag = q_type'($urandom & ((32'h1 << bits) - 1));
      return ($urandom_range(0, 1) == 1) ? -mag : mag;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_pause(bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic void check_field(string field, logic signed [63:0] exp_v,
                                       logic signed [63:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
         error_count++;
      end
   endfunction

   // ---------------------------------------------------------------- request driver

   // a new item goes out only when the bus is free: idle, or the last one just transferred
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_hold = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted_results.push_back(apply_to_store(on_bus));
            accepted_count++;
         end
         if ($urandom_range(0, 199) == 0)
            send_calm = !send_calm;
         if (!req_bus.valid || req_bus.ready) begin
            if (send_hold > 0) begin
               req_bus.valid <= 1'b0;
               send_hold--;
            end else if (request_backlog.size() > 0) begin
               on_bus = request_backlog.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.action   <= on_bus.action;
               req_bus.exponent <= on_bus.exponent;
               req_bus.amount   <= on_bus.amount;
               req_bus.x_low    <= on_bus.x_low;
               req_bus.x_high   <= on_bus.x_high;
               send_hold = pick_pause(send_calm);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- response monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.value     = rsp_bus.value;
            got.slope     = rsp_bus.slope;
            got.integral  = rsp_bus.integral;
            got.degree    = rsp_bus.degree;
            got.is_zero   = rsp_bus.is_zero;
            got.saturated = rsp_bus.saturated;
            if (predicted_results.size() == 0) begin
               $error("response transfer with no result owed");
               error_count++;
            end else begin
               want = predicted_results.pop_front();
               check_field("value", want.value, got.value);
               check_field("slope", want.slope, got.slope);
               check_field("integral", want.integral, got.integral);
               check_field("degree", want.degree, got.degree);
               check_field("is_zero", want.is_zero, got.is_zero);
               check_field("saturated", want.saturated, got.saturated);
            end
         end
         if ($urandom_range(0, 199) == 0)
            ready_calm = !ready_calm;
         if (ready_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            ready_hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
            ready_hold = pick_pause(ready_calm);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      int top, xbits;
      clock            = 1'b0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.action   = '0;
      req_bus.exponent = '0;
      req_bus.amount   = '0;
      req_bus.x_low    = '0;
      req_bus.x_high   = '0;
      rsp_bus.ready    = 1'b0;
      foreach (coef_model[i]) coef_model[i] = '0;
      deg_model = '0;

      // empty store evaluated at the extreme points
      queue_item(ACT_EVAL, '0, '0, 32'sh8000_0000, 32'sh7fff_ffff);
      // constant term at full scale, then pushed past it
      queue_item(ACT_SET, 5'd0, 32'sh7fff_ffff, '0, '0);
      queue_item(ACT_ADD, 5'd0, 32'sh0000_0001, '0, '0);
      // top coefficient at negative full scale, then pushed below it
      queue_item(ACT_SET, 5'd31, 32'sh8000_0000, '0, '0);
      queue_item(ACT_ADD, 5'd31, 32'shffff_ffff, '0, '0);
      queue_item(ACT_EVAL, '0, '0, -Q_ONE, Q_ONE);
      // removing the top term makes the degree search walk all the way down
      queue_item(ACT_SET, 5'd31, '0, '0, '0);
      queue_item(ACT_SET, 5'd0, '0, '0, '0);
      // a plain cubic
      queue_item(ACT_SET, 5'd3, Q_ONE + Q_HALF, '0, '0);
      queue_item(ACT_SET, 5'd1, -2 * Q_ONE, '0, '0);
      queue_item(ACT_SET, 5'd0, Q_ONE / 4, '0, '0);
      queue_item(ACT_EVAL, '0, '0, -(Q_ONE + Q_HALF), 2 * Q_ONE);
      queue_item(ACT_EVAL, '0, '0, '0, '0);
      queue_item(ACT_EVAL, '0, '0, 32'sh8000_0000, 32'sh7fff_ffff);
      queue_item(ACT_ADD, 5'd3, '0, '0, '0);
      // add that cancels a coefficient to zero
      queue_item(ACT_ADD, 5'd1, 2 * Q_ONE, '0, '0);
      queue_item(ACT_CLEAR, 5'd7, 32'sh1234_5678, '0, '0);
      queue_item(ACT_EVAL, '0, '0, -Q_ONE, Q_ONE);
      // one-lsb terms for product rounding ties and reciprocal ties of either sign
      queue_item(ACT_SET, 5'd1, 32'sh0000_0001, '0, '0);
      queue_item(ACT_SET, 5'd2, -32'sh0000_0003, '0, '0);
      queue_item(ACT_SET, 5'd5, 32'sh0000_0001, '0, '0);
      queue_item(ACT_EVAL, '0, '0, -Q_HALF, Q_HALF);
      queue_item(ACT_SET, 5'd1, -32'sh0000_0001, '0, '0);
      queue_item(ACT_EVAL, '0, '0, Q_HALF, -Q_HALF);

      // random part: mostly a polynomial built up and then evaluated, some pure noise
      while (request_backlog.size() < RANDOM_ITEMS + 24) begin
         if ($urandom_range(0, 99) < 78) begin
            if ($urandom_range(0, 2) == 0)
               queue_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
            top = ($urandom_range(0, 4) == 0) ? $urandom_range(8, MAX_DEG)
                                              : $urandom_range(0, 7);
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 7) == 0)
                  queue_item(ACT_SET, $urandom_range(0, top), '0, $urandom, $urandom);
               else if ($urandom_range(0, 9) == 0)
                  queue_item(ACT_ADD, $urandom_range(0, top), $urandom, $urandom, $urandom);
               else
                  queue_item(($urandom_range(0, 3) == 0) ? ACT_ADD : ACT_SET,
                             $urandom_range(0, top), rand_q($urandom_range(4, 22)),
                             $urandom, $urandom);
            end
            // keep |x| near one for high degrees so not every result clamps
            xbits = (top >= 8) ? $urandom_range(12, 17) : $urandom_range(12, 20);
            repeat ($urandom_range(1, 4))
               queue_item(ACT_EVAL, $urandom, $urandom, rand_q(xbits), rand_q(xbits));
         end else begin
            queue_item(action_type'($urandom_range(0, 3)), $urandom, $urandom,
                       $urandom, $urandom);
         end
      end
      total_items = request_backlog.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items || predicted_results.size() != 0)
         @(posedge clock);
      // room for a stray late transfer to show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
